/* rtl/core/assert_macros.svh */
// Assertion macros shared by the checker files.
// Each macro asserts one clocked implication, disabled while the reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/calt_pkg.sv */
// Package for the client address lease table: widths, register indexes,
// status codes and the structs passed between the sequencer, RAM and top level.
package calt_pkg;

   localparam int POOL_MAX   = 8;
   localparam int ID_W       = 16;
   localparam int IP_W       = 32;
   localparam int COUNT_W    = 4;
   localparam int LU_W       = $clog2(POOL_MAX + 1);
   localparam int IDX_W      = (POOL_MAX > 1) ? $clog2(POOL_MAX) : 1;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_BASE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL_COUNT = 1'b1;

   localparam logic [IP_W-1:0]    POOL_BASE_RESET  = 32'hC0A8010A;
   localparam logic [COUNT_W-1:0] POOL_COUNT_RESET = 4'd5;

   typedef enum logic [1:0] {
      ST_REUSED   = 2'd0,
      ST_ASSIGNED = 2'd1,
      ST_NONE     = 2'd2
   } calt_status_type;

   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  addr;
      logic [ID_W-1:0]   wr_data;
   } calt_ram_req_type;

   typedef struct packed {
      logic              valid;
      calt_status_type   status;
      logic [IP_W-1:0]   ip_addr;
   } calt_result_type;

   function automatic logic [LU_W-1:0] calt_pool_size(input logic [COUNT_W-1:0] count);
      logic [LU_W-1:0] size;
      if (int'(count) > POOL_MAX) begin
         size = LU_W'(POOL_MAX);
      end else begin
         size = LU_W'(count);
      end
      return size;
   endfunction

endpackage

/* rtl/core/calt_if.sv */
// Channel interfaces for the client address lease table: request, response
// and register write. Depends on calt_pkg.
interface calt_req_if;
   import calt_pkg::*;
   logic            valid;
   logic            ready;
   logic [ID_W-1:0] src_port;
   modport source(output valid, output src_port, input ready);
   modport sink(input valid, input src_port, output ready);
endinterface

interface calt_rsp_if;
   import calt_pkg::*;
   logic            valid;
   logic            ready;
   calt_status_type status;
   logic [IP_W-1:0] ip_addr;
   modport source(output valid, output status, output ip_addr, input ready);
   modport sink(input valid, input status, input ip_addr, output ready);
endinterface

interface calt_csr_if;
   import calt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source(output valid, output index, output data, input ready);
   modport sink(input valid, input index, input data, output ready);
endinterface

/* rtl/core/client_address_lease_table.sv */
// Client address lease table: a request with a client identifier returns the
// client's existing lease, a newly assigned pool address (highest free slot
// first), or none-available. One compare unit reads the leases one by one
// from the lease RAM, so a request holds the input until it hits a lease,
// until a new client gets an address after every lease misses, or until all
// pool addresses are already leased. The response sits in an output register,
// so the next request is taken while it waits. Writing register 1 (pool_count)
// drops every lease; register 0 (pool_base_addr) moves the pool without
// dropping leases.
// Depends on calt_pkg, calt_if, calt_lease_ram and calt_ctrl.
module client_address_lease_table (
   input  logic          clock,
   input  logic          reset,
   calt_req_if.sink      req_chan,
   calt_rsp_if.source    rsp_chan,
   calt_csr_if.sink      csr_chan
);
   import calt_pkg::*;

   logic [IP_W-1:0]    base_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               rsp_valid_ff;
   calt_status_type    rsp_status_ff;
   logic [IP_W-1:0]    rsp_ip_ff;

   logic               csr_xfer;
   logic               lease_clear;
   logic               result_ready;
   calt_ram_req_type   ram_req;
   logic [ID_W-1:0]    ram_rd_data;
   calt_result_type    result;

   assign csr_chan.ready = 1'b1;
   assign csr_xfer       = csr_chan.valid && csr_chan.ready;
   assign lease_clear    = csr_xfer && (csr_chan.index == CSR_POOL_COUNT);
   assign result_ready   = !rsp_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= POOL_BASE_RESET;
         count_ff     <= POOL_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_xfer) begin
            unique case (csr_chan.index)
               CSR_POOL_BASE:  base_ff  <= csr_chan.data[IP_W-1:0];
               CSR_POOL_COUNT: count_ff <= csr_chan.data[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (result.valid && result_ready) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= result.status;
            rsp_ip_ff     <= result.ip_addr;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   calt_lease_ram u_lease_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (ram_rd_data)
   );

   calt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_src_port  (req_chan.src_port),
      .req_ready     (req_chan.ready),
      .lease_clear   (lease_clear),
      .pool_size     (calt_pool_size(count_ff)),
      .pool_base     (base_ff),
      .ram_req       (ram_req),
      .ram_rd_data   (ram_rd_data),
      .result        (result),
      .result_ready  (result_ready)
   );

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.status  = rsp_status_ff;
   assign rsp_chan.ip_addr = rsp_ip_ff;

endmodule

/* rtl/core/calt_lease_ram.sv */
// Lease RAM: one client identifier per lease, single port, registered read.
// Depends on calt_pkg.
module calt_lease_ram (
   input  logic                         clock,
   input  calt_pkg::calt_ram_req_type   ram_req,
   output logic [calt_pkg::ID_W-1:0]    rd_data
);
   import calt_pkg::*;

   logic [ID_W-1:0] mem [POOL_MAX];
   logic [ID_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.addr] <= ram_req.wr_data;
      end
      rd_data_ff <= mem[ram_req.addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/calt_ctrl.sv */
// Lease sequencer: walks the lease RAM with one shared compare, allocates
// new leases and forms the address with one shared adder. Depends on calt_pkg.
module calt_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic [calt_pkg::ID_W-1:0]       req_src_port,
   output logic                            req_ready,
   input  logic                            lease_clear,
   input  logic [calt_pkg::LU_W-1:0]       pool_size,
   input  logic [calt_pkg::IP_W-1:0]       pool_base,
   output calt_pkg::calt_ram_req_type      ram_req,
   input  logic [calt_pkg::ID_W-1:0]       ram_rd_data,
   output calt_pkg::calt_result_type       result,
   input  logic                            result_ready
);
   import calt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CMP,
      S_ALLOC,
      S_ADD,
      S_DONE
   } state_type;

   state_type       state_ff;
   logic [ID_W-1:0] id_ff;
   logic [LU_W-1:0] k_ff;
   logic [LU_W-1:0] used_ff;
   logic [LU_W-1:0] slot_ff;
   calt_status_type status_ff;
   logic [IP_W-1:0] ip_ff;

   logic [LU_W-1:0] k_plus;
   logic [LU_W-1:0] size_m1;

   assign k_plus  = k_ff + LU_W'(1);
   assign size_m1 = pool_size - LU_W'(1);

   always_comb begin
      ram_req.wr_en   = 1'b0;
      ram_req.addr    = k_ff[IDX_W-1:0];
      ram_req.wr_data = id_ff;
      if (state_ff == S_ALLOC && used_ff < pool_size) begin
         ram_req.wr_en = 1'b1;
         ram_req.addr  = used_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  id_ff    <= req_src_port;
                  k_ff     <= '0;
                  state_ff <= (used_ff == '0) ? S_ALLOC : S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_CMP;
            end
            S_CMP: begin
               if (ram_rd_data == id_ff) begin
                  slot_ff   <= size_m1 - k_ff;
                  status_ff <= ST_REUSED;
                  state_ff  <= S_ADD;
               end else if (k_plus < used_ff) begin
                  k_ff     <= k_plus;
                  state_ff <= S_READ;
               end else begin
                  state_ff <= S_ALLOC;
               end
            end
            S_ALLOC: begin
               if (used_ff < pool_size) begin
                  used_ff   <= used_ff + LU_W'(1);
                  slot_ff   <= size_m1 - used_ff;
                  status_ff <= ST_ASSIGNED;
                  state_ff  <= S_ADD;
               end else begin
                  status_ff <= ST_NONE;
                  ip_ff     <= '0;
                  state_ff  <= S_DONE;
               end
            end
            S_ADD: begin
               ip_ff    <= pool_base + IP_W'(slot_ff);
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (result_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (lease_clear) begin
            used_ff <= '0;
         end
      end
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign result.valid   = (state_ff == S_DONE);
   assign result.status  = status_ff;
   assign result.ip_addr = ip_ff;

endmodule

/* rtl/core/calt_checker.sv */
// Port-level checks for the client address lease table, bound to the top level.
// Depends on calt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module calt_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  calt_pkg::calt_status_type    rsp_status,
   input  logic [calt_pkg::IP_W-1:0]    rsp_ip_addr
);
   import calt_pkg::*;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_ip_addr), "response changed while stalled")
   `ASSERT_IMPLIES(a_none_zero, clock, reset, rsp_valid && rsp_status == ST_NONE, rsp_ip_addr == '0, "none-available response carries an address")
   `ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "request taken while a lookup runs")
   `ASSERT_IMPLIES(a_ready_with_rsp, clock, reset, $rose(rsp_valid), req_ready, "input not ready when a response is issued")

endmodule

bind client_address_lease_table calt_checker u_calt_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_status  (rsp_chan.status),
   .rsp_ip_addr (rsp_chan.ip_addr)
);
